### design/mht_pkg.sv
package mht_pkg;

	// default sizing
	localparam int NOTE_COUNT_DEF = 128;
	localparam int COUNT_BITS_DEF = 8;

	// fixed field layout
	localparam int STATUS_W   = 8;
	localparam int DATA_W     = 7;
	localparam int KIND_W     = 4;
	localparam int MASK_W     = 128;
	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 136;

	// status nibble codes
	localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 4'h8;
	localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 4'h9;
	localparam logic [KIND_W-1:0] KIND_CTRL     = 4'hB;

	// controller numbers
	localparam logic [DATA_W-1:0] CC_SUSTAIN       = 7'd64;
	localparam logic [DATA_W-1:0] CC_ALL_SOUND_OFF = 7'd120;
	localparam logic [DATA_W-1:0] CC_ALL_NOTES_OFF = 7'd123;

	localparam logic [DATA_W-1:0] PEDAL_THRESHOLD = 7'd64;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_APPLY,
		ST_PUSH
	} state_t;

	typedef struct packed {
		logic capture;
		logic apply;
		logic load;
	} cmd_t;

endpackage

### design/midi_held_note_tracker.sv
// midi held-note tracker: each input word is one complete midi message (channel ignored)
// and each message yields exactly one output word holding the 128-note active mask and
// the sustain pedal state after the message is applied. a note is active while its hold
// count is nonzero or its sustained flag is set. note on bumps the count (saturating) and
// clears the flag; note off or note on with zero velocity drops the count (floored at zero)
// and sets the flag if the count is zero with the pedal down; controller 64 moves the pedal
// and, on release, drops flags of notes with zero count; controllers 120 and 123 clear all
// counts and flags. a message passes through the accept, apply and push states: in the
// accept state the hold-count ram read is issued off the input bus and registered at
// acceptance, the apply state updates the notes, and the push state loads the result
// into the output register once it is free. the input is taken again in the cycle after
// the result is loaded, even while it still waits at the output, but not while a message
// is in flight; a result held back by the receiver stalls the input only once the next
// message is ready to load. hold counts live in a single-port-write ram; the per-note
// nonzero bits mark which ram entries are valid, so reset and the all-notes-off
// controllers need no clearing pass.
module midi_held_note_tracker #(
	parameter int NOTE_COUNT = mht_pkg::NOTE_COUNT_DEF,
	parameter int COUNT_BITS = mht_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input message stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mht_pkg::S_TDATA_W-1:0] s_tdata,  // status_byte[7:0], data_one[14:8],
	                                                // data_two[21:15], zero pad
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mht_pkg::M_TDATA_W-1:0] m_tdata   // active_low[63:0], active_high[127:64],
	                                                // pedal_down[128], zero pad
);

	mht_pkg::cmd_t cmd;

	// sequencer: accept, apply, hand off to the output register
	mht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// note state, count ram and output word register
	mht_datapath #(
		.NOTE_COUNT (NOTE_COUNT),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata)
	);

endmodule

### design/mht_ram.sv
module mht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/mht_ctrl.sv
module mht_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output mht_pkg::cmd_t cmd
);

	mht_pkg::state_t state_q;
	mht_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == mht_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mht_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.apply   = 1'b0;
		cmd.load    = 1'b0;
		unique case (state_q)
			mht_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = mht_pkg::ST_APPLY;
				end
			end
			mht_pkg::ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = mht_pkg::ST_PUSH;
			end
			mht_pkg::ST_PUSH: begin
				if (out_free) begin
					cmd.load = 1'b1;
					state_d  = mht_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mht_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### design/mht_datapath.sv
module mht_datapath #(
	parameter int NOTE_COUNT = mht_pkg::NOTE_COUNT_DEF,
	parameter int COUNT_BITS = mht_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mht_pkg::cmd_t                   cmd,
	input  logic [mht_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic [mht_pkg::M_TDATA_W-1:0]   m_tdata
);

	localparam int AW = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [mht_pkg::DATA_W:0] NOTE_LIMIT = (mht_pkg::DATA_W + 1)'(NOTE_COUNT);

	// captured message
	logic [mht_pkg::KIND_W-1:0] kind_q;
	logic [mht_pkg::DATA_W-1:0] d1_q;
	logic [mht_pkg::DATA_W-1:0] d2_q;

	// per-note state; nz_q also marks which count entries are valid
	logic [NOTE_COUNT-1:0] nz_q, nz_d;
	logic [NOTE_COUNT-1:0] flag_q, flag_d;
	logic                  pedal_q, pedal_d;

	logic [mht_pkg::M_TDATA_W-1:0] out_q;

	logic [AW-1:0]         note;
	logic                  note_ok;
	logic [COUNT_BITS-1:0] ram_rdata;
	logic [COUNT_BITS-1:0] cnt_cur;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [COUNT_BITS-1:0] cnt_dec;
	logic [COUNT_BITS-1:0] ram_wdata;
	logic                  ram_we;
	logic [mht_pkg::MASK_W-1:0] mask;

	assign note    = d1_q[AW-1:0];
	assign note_ok = {1'b0, d1_q} < NOTE_LIMIT;
	assign cnt_cur = nz_q[note] ? ram_rdata : '0;
	assign cnt_inc = (cnt_cur == CNT_MAX) ? cnt_cur : COUNT_BITS'(cnt_cur + 1'b1);
	assign cnt_dec = (cnt_cur == '0) ? cnt_cur : COUNT_BITS'(cnt_cur - 1'b1);

	// count read is issued straight off the input bus on every cycle
	mht_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (NOTE_COUNT)
	) u_count_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (note),
		.wdata (ram_wdata),
		.raddr (s_tdata[mht_pkg::STATUS_W +: AW]),
		.rdata (ram_rdata)
	);

	always_comb begin
		nz_d      = nz_q;
		flag_d    = flag_q;
		pedal_d   = pedal_q;
		ram_we    = 1'b0;
		ram_wdata = cnt_inc;
		if (cmd.apply) begin
			unique case (kind_q) inside
				mht_pkg::KIND_CTRL: begin
					if (d1_q == mht_pkg::CC_ALL_NOTES_OFF ||
					    d1_q == mht_pkg::CC_ALL_SOUND_OFF) begin
						nz_d   = '0;
						flag_d = '0;
					end else if (d1_q == mht_pkg::CC_SUSTAIN) begin
						pedal_d = (d2_q >= mht_pkg::PEDAL_THRESHOLD);
						if (!pedal_d) begin
							flag_d = flag_q & nz_q;
						end
					end
				end
				mht_pkg::KIND_NOTE_ON, mht_pkg::KIND_NOTE_OFF: begin
					if (note_ok) begin
						ram_we = 1'b1;
						if (kind_q == mht_pkg::KIND_NOTE_ON && d2_q != '0) begin
							ram_wdata    = cnt_inc;
							nz_d[note]   = 1'b1;
							flag_d[note] = 1'b0;
						end else begin
							ram_wdata  = cnt_dec;
							nz_d[note] = (cnt_dec != '0);
							if (cnt_dec == '0 && pedal_q) begin
								flag_d[note] = 1'b1;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	for (genvar n = 0; n < mht_pkg::MASK_W; n++) begin : g_mask
		if (n < NOTE_COUNT) begin : g_live
			assign mask[n] = nz_q[n] | flag_q[n];
		end else begin : g_dead
			assign mask[n] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nz_q    <= '0;
			flag_q  <= '0;
			pedal_q <= 1'b0;
		end else begin
			nz_q    <= nz_d;
			flag_q  <= flag_d;
			pedal_q <= pedal_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= s_tdata[mht_pkg::STATUS_W-1 -: mht_pkg::KIND_W];
			d1_q   <= s_tdata[mht_pkg::STATUS_W +: mht_pkg::DATA_W];
			d2_q   <= s_tdata[mht_pkg::STATUS_W + mht_pkg::DATA_W +: mht_pkg::DATA_W];
		end
		if (cmd.load) begin
			out_q <= {7'd0, pedal_q, mask};
		end
	end

	assign m_tdata = out_q;

endmodule
